// ===== sv/dpas_pkg.sv =====
// ============================================================================
// dpas_pkg - shared types and constants for the data-processing ALU/shifter
// Opcode and shift-type codes, data and field widths, flag struct.
// ============================================================================
package dpas_pkg;

  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned INSN_W    = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned RIDX_W    = 4;   // width of Rn/Rd/Rm/Rs fields
  localparam int unsigned SHAMT_W   = 5;

  // immediate rotate is twice the 4-bit field
  localparam int unsigned ROT_SCALE = 2;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13
  } alu_op_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
  } flags_t;

endpackage

// ===== sv/data_processing_alu_shifter_core.sv =====
// ============================================================================
// data_processing_alu_shifter_core - data-processing execute stage
// Executes one data-processing instruction per transfer against a 16-entry
// register file (synchronous RAM) and N/Z/C flags.
// ============================================================================
// Usage:
//   Input channel : instruction_word_i with in_valid_i / in_stall_o.
//   Output channel: result fields with out_valid_o / out_stall_i.
//   A transfer happens at a rising edge with valid high and stall low.
// Pipeline: the input transfer edge reads Rn, Rm and Rs from the register
//   RAM into the operand registers. The execute stage then forwards the
//   most recent write-back, shifts operand 2, runs the ALU, writes Rd back
//   and loads the output register, which drives the result fields.
// Throughput: one instruction per cycle, back to back while the output is
//   not stalled; the read of a younger instruction overlaps the write-back
//   of the older one and the write-back register forwards the value.
// Register file: two RAM copies with identical writes; copy A serves the
//   Rn and Rm reads, copy B the Rs read. Per-entry valid bits make a
//   never-written register read as zero, so reset needs no clearing pass.
// Reset: flags, valid bits and pipeline valids clear at once; the block
//   accepts an instruction in the first cycle after reset.
// Stall: when the output is stalled with a result waiting, the execute
//   stage holds its instruction and the input stalls only once that stage
//   is full too; no register write happens while the stage holds.
// ============================================================================
module data_processing_alu_shifter_core
  import dpas_pkg::*;
#(
  parameter int unsigned RegCount = REG_COUNT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [INSN_W-1:0] instruction_word_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] result_value_o,
  output logic [RIDX_W-1:0] dest_index_o,
  output logic              dest_written_o,
  output logic              flag_negative_o,
  output logic              flag_zero_o,
  output logic              flag_carry_o,
  output logic              illegal_opcode_o
);

  localparam int unsigned IdxW = $clog2(RegCount);

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic ex_valid_q;
  logic out_valid_q;
  logic ex_adv;     // execute stage moves into the output register
  logic in_xfer;

  assign ex_adv     = ex_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = ex_valid_q && !ex_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Register file RAM, read on input transfer
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] mem_a [RegCount];
  logic [DATA_W-1:0] mem_b [RegCount];
  logic [RegCount-1:0] reg_vld_q;

  logic [IdxW-1:0] rd_rn_addr, rd_rm_addr, rd_rs_addr;
  assign rd_rn_addr = instruction_word_i[16 +: IdxW];
  assign rd_rm_addr = instruction_word_i[0  +: IdxW];
  assign rd_rs_addr = instruction_word_i[8  +: IdxW];

  logic [DATA_W-1:0] rn_data_q, rm_data_q, rs_data_q;
  logic              rn_vld_q, rm_vld_q, rs_vld_q;
  logic [INSN_W-1:0] insn_q;

  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [DATA_W-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rn_data_q <= mem_a[rd_rn_addr];
      rm_data_q <= mem_a[rd_rm_addr];
      rs_data_q <= mem_b[rd_rs_addr];
      insn_q    <= instruction_word_i;
    end
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
    end
  end

  // last write-back, forwarded over the read-before-write RAM
  logic              fwd_vld_q;
  logic [IdxW-1:0]   fwd_addr_q;
  logic [DATA_W-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_vld_q <= '0;
      rn_vld_q  <= 1'b0;
      rm_vld_q  <= 1'b0;
      rs_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        rn_vld_q <= reg_vld_q[rd_rn_addr];
        rm_vld_q <= reg_vld_q[rd_rm_addr];
        rs_vld_q <= reg_vld_q[rd_rs_addr];
      end
      if (wr_en) begin
        reg_vld_q[wr_addr] <= 1'b1;
        fwd_vld_q          <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= wr_addr;
      fwd_data_q <= wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Execute stage: decode, operand select with forwarding
  // --------------------------------------------------------------------------
  logic          imm_sel, set_flags, shamt_reg;
  alu_op_e       opcode;
  shift_e        sh_type;
  logic [IdxW-1:0] rn_idx, rm_idx, rs_idx, rd_idx;
  logic [7:0]    imm8;
  logic [3:0]    rot4;

  assign imm_sel   = insn_q[25];
  assign opcode    = alu_op_e'(insn_q[24:21]);
  assign set_flags = insn_q[20];
  assign rn_idx    = insn_q[16 +: IdxW];
  assign rd_idx    = insn_q[12 +: IdxW];
  assign rs_idx    = insn_q[8 +: IdxW];
  assign rm_idx    = insn_q[0 +: IdxW];
  assign shamt_reg = insn_q[4];
  assign sh_type   = shift_e'(insn_q[6:5]);
  assign imm8      = insn_q[7:0];
  assign rot4      = insn_q[11:8];

  logic [DATA_W-1:0] rn_val, rm_val, rs_val;

  always_comb begin
    rn_val = rn_vld_q ? rn_data_q : '0;
    rm_val = rm_vld_q ? rm_data_q : '0;
    rs_val = rs_vld_q ? rs_data_q : '0;
    if (fwd_vld_q && fwd_addr_q == rn_idx) rn_val = fwd_data_q;
    if (fwd_vld_q && fwd_addr_q == rm_idx) rm_val = fwd_data_q;
    if (fwd_vld_q && fwd_addr_q == rs_idx) rs_val = fwd_data_q;
  end

  // --------------------------------------------------------------------------
  // Operand 2 shifter
  // --------------------------------------------------------------------------
  logic [SHAMT_W-1:0]  shamt, imm_rot;
  logic [2*DATA_W-1:0] rot_pair, imm_pair;
  logic [DATA_W-1:0]   op2;
  logic                sh_carry;

  assign shamt   = shamt_reg ? rs_val[SHAMT_W-1:0] : insn_q[11:7];
  assign imm_rot = SHAMT_W'(ROT_SCALE * rot4);
  assign imm_pair = {{(DATA_W-8){1'b0}}, imm8, {(DATA_W-8){1'b0}}, imm8} >> imm_rot;
  assign rot_pair = {rm_val, rm_val} >> shamt;

  always_comb begin
    op2      = rm_val;
    sh_carry = 1'b0;
    if (imm_sel) begin
      op2 = imm_pair[DATA_W-1:0];
    end else if (shamt != '0) begin
      case (sh_type)
        SH_LSL: begin
          op2      = rm_val << shamt;
          sh_carry = rm_val[SHAMT_W'(0) - shamt];
        end
        SH_LSR: begin
          op2      = rm_val >> shamt;
          sh_carry = rm_val[shamt - SHAMT_W'(1)];
        end
        SH_ASR: begin
          op2      = $unsigned($signed(rm_val) >>> shamt);
          sh_carry = rm_val[shamt - SHAMT_W'(1)];
        end
        default: begin
          op2      = rot_pair[DATA_W-1:0];
          sh_carry = rm_val[shamt - SHAMT_W'(1)];
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // ALU: one shared 33-bit adder for ADD / SUB / CMP / RSB
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] add_x, add_y;
  logic              add_sub;
  logic [DATA_W:0]   add_sum;

  always_comb begin
    add_x   = rn_val;
    add_y   = op2;
    add_sub = 1'b1;
    case (opcode)
      OP_RSB: begin
        add_x = op2;
        add_y = rn_val;
      end
      OP_ADD: add_sub = 1'b0;
      default: ;
    endcase
  end

  // carry out of x + ~y + 1 is "no borrow", i.e. x >= y
  assign add_sum = {1'b0, add_x} + {1'b0, add_sub ? ~add_y : add_y}
                 + {{DATA_W{1'b0}}, add_sub};

  logic [DATA_W-1:0] alu_res;
  logic              alu_carry, legal, do_write;

  always_comb begin
    alu_res   = '0;
    alu_carry = sh_carry;
    legal     = 1'b1;
    do_write  = 1'b1;
    unique case (opcode)
      OP_AND, OP_TST: alu_res = rn_val & op2;
      OP_EOR, OP_TEQ: alu_res = rn_val ^ op2;
      OP_ORR:         alu_res = rn_val | op2;
      OP_MOV:         alu_res = op2;
      OP_SUB, OP_CMP, OP_RSB, OP_ADD: begin
        alu_res   = add_sum[DATA_W-1:0];
        alu_carry = add_sum[DATA_W];
      end
      default: legal = 1'b0;
    endcase
    case (opcode)
      OP_TST, OP_TEQ, OP_CMP: do_write = 1'b0;
      default: ;
    endcase
    if (!legal) do_write = 1'b0;
  end

  assign wr_en   = ex_adv && do_write;
  assign wr_addr = rd_idx;
  assign wr_data = alu_res;

  // --------------------------------------------------------------------------
  // Flags and output register
  // --------------------------------------------------------------------------
  flags_t flags_q, flags_d;

  always_comb begin
    flags_d = flags_q;
    if (legal && set_flags) begin
      flags_d.n = alu_res[DATA_W-1];
      flags_d.z = (alu_res == '0);
      flags_d.c = alu_carry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (in_xfer) begin
        ex_valid_q <= 1'b1;
      end else if (ex_adv) begin
        ex_valid_q <= 1'b0;
      end
      if (ex_adv) begin
        out_valid_q <= 1'b1;
        flags_q     <= flags_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic [DATA_W-1:0] res_q;
  logic [RIDX_W-1:0] dest_q;
  logic              written_q, illegal_q;
  flags_t            oflags_q;

  always_ff @(posedge clk_i) begin
    if (ex_adv) begin
      res_q     <= alu_res;
      dest_q    <= insn_q[15:12];
      written_q <= do_write;
      illegal_q <= !legal;
      oflags_q  <= flags_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_value_o   = res_q;
  assign dest_index_o     = dest_q;
  assign dest_written_o   = written_q;
  assign flag_negative_o  = oflags_q.n;
  assign flag_zero_o      = oflags_q.z;
  assign flag_carry_o     = oflags_q.c;
  assign illegal_opcode_o = illegal_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_illegal_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && illegal_opcode_o |-> !dest_written_o)
    else $error("illegal opcode reported a register write");

  a_wr_only_on_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ex_valid_q && ex_adv)
    else $error("register write without execute stage retiring");

  a_flags_hold_illegal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_adv && !legal |=> flags_q == $past(flags_q))
    else $error("flags changed on illegal opcode");

  a_flags_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ex_adv |=> $stable(flags_q))
    else $error("flags changed with no instruction retiring");

  a_out_matches_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_adv |=> oflags_q == flags_q)
    else $error("reported flags differ from flag state");

endmodule
